[src/fixed_point_arctangent_unit_defines.svh]
// ============================================================================
// Assertion macros for the fixed-point arctangent unit
// Shared helpers that wrap a concurrent assertion with clock and reset.
// ============================================================================
`ifndef FIXED_POINT_ARCTANGENT_UNIT_DEFINES_SVH
`define FIXED_POINT_ARCTANGENT_UNIT_DEFINES_SVH

// Assertion on an explicit clock and active-low reset.
`define FPAT_ASSERT_CLK(lbl, ck, rn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) else $error(msg);

// Assertion on the block's own clock and reset.
`define FPAT_ASSERT(lbl, prop, msg) \
	`FPAT_ASSERT_CLK(lbl, clk, arst_n, prop, msg)

`endif

[src/fpat_pkg.sv]
// ============================================================================
// fpat_pkg
// Types and constants shared by the fixed-point arctangent unit.
// ============================================================================
`default_nettype none

package fpat_pkg;

	// Default number of unrolled continued-fraction terms.
	localparam int MAX_TERMS_DEF = 24;
	localparam int TERM_W        = 5;
	localparam logic [TERM_W-1:0] TERM_COUNT_RST = 5'd24;

	// Function codes.
	localparam logic [1:0] ACT_ATAN  = 2'd0;
	localparam logic [1:0] ACT_ATAN2 = 2'd1;
	localparam logic [1:0] ACT_ASIN  = 2'd2;
	localparam logic [1:0] ACT_ACOS  = 2'd3;

	// Angle constants in Q.30 and one in Q16.16.
	localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
	localparam logic [31:0] PI_Q30      = 32'd3373259426;
	localparam logic [31:0] ONE_Q16     = 32'd65536;

	// Input transaction.
	typedef struct packed {
		logic [1:0]          action;
		logic signed [31:0]  y_value;
		logic signed [31:0]  x_value;
	} fpat_in_t;

	// Result transaction.
	typedef struct packed {
		logic signed [31:0]  angle;
		logic                status;
	} fpat_out_t;

	// Per-item control flags carried along the pipeline.
	typedef struct packed {
		logic err;
		logic zero;
		logic inv;
		logic xneg;
		logic yneg;
		logic is_acos;
	} fpat_ctl_t;

endpackage

`default_nettype wire

[src/fixed_point_arctangent_unit.sv]
// Throughput: one transaction per cycle; busy is never raised.
// The pipeline runs through the unrolled continued-fraction terms, each a
// 34-stage pipelined divider, plus the root stage and the ratio and final dividers.
// Reset clears every valid bit and returns term_count to 24.
// ============================================================================
// fixed_point_arctangent_unit
// Pipelined atan, atan2, asin and acos with a continued-fraction core.
// ============================================================================
`default_nettype none

module fixed_point_arctangent_unit #(
	parameter int MAX_TERMS = fpat_pkg::MAX_TERMS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  fpat_pkg::fpat_in_t  item,
	output logic                done,
	output fpat_pkg::fpat_out_t result,
	input  logic                cfg_we,
	input  logic [fpat_pkg::TERM_W-1:0] cfg_wdata
);
	import fpat_pkg::*;

	typedef struct packed {
		logic [1:0]  act;
		logic        xneg;
		logic        yneg;
		logic        err;
		logic [31:0] xm;
		logic [31:0] ym;
	} front_t;

	typedef struct packed {
		logic [30:0] r;
		logic [30:0] sq;
		fpat_ctl_t   ctl;
	} tside_t;

	logic [TERM_W-1:0] term_count_q;
	logic              accept;

	// Term count register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_count_q <= TERM_COUNT_RST;
		end else if (cfg_we) begin
			term_count_q <= cfg_wdata;
		end
	end

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Stage 1: magnitudes and signs.
	logic        v_s1;
	logic [1:0]  act_s1;
	logic        xneg_s1, yneg_s1;
	logic [31:0] xm_s1, ym_s1;
	logic [31:0] xraw, yraw;

	assign xraw = item.x_value;
	assign yraw = item.y_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		act_s1  <= item.action;
		xneg_s1 <= xraw[31];
		yneg_s1 <= yraw[31];
		xm_s1   <= xraw[31] ? (~xraw + 32'd1) : xraw;
		ym_s1   <= yraw[31] ? (~yraw + 32'd1) : yraw;
	end

	// Stage 2: domain check and radicand (1 - x^2) in Q.60.
	logic        v_s2;
	logic [61:0] rad_s2;
	front_t      fr_s2;
	logic [33:0] xsq;
	logic [32:0] one_minus;

	always_comb begin
		xsq       = {17'b0, xm_s1[16:0]} * {17'b0, xm_s1[16:0]};
		one_minus = 33'h1_0000_0000 - xsq[32:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		rad_s2     <= {1'b0, one_minus, 28'b0};
		fr_s2.act  <= act_s1;
		fr_s2.xneg <= xneg_s1;
		fr_s2.yneg <= yneg_s1;
		fr_s2.xm   <= xm_s1;
		fr_s2.ym   <= ym_s1;
		fr_s2.err  <= ((act_s1 == ACT_ASIN) || (act_s1 == ACT_ACOS)) && (xm_s1 > ONE_Q16);
	end

	// Square root for asin and acos.
	logic        sq_v;
	logic [30:0] root;
	front_t      fr_o;

	fpat_sqrt #(
		.RW     (31),
		.SIDE_W ($bits(front_t))
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s2),
		.in_rad    (rad_s2),
		.in_side   (fr_s2),
		.out_valid (sq_v),
		.out_root  (root),
		.out_side  (fr_o)
	);

	// Stage 3: pick the vector for the requested function.
	logic        v_s3;
	logic [31:0] ay_s3, ax_s3;
	fpat_ctl_t   ctl_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= sq_v;
		end
	end

	always_ff @(posedge clk) begin
		ctl_s3.err     <= fr_o.err;
		ctl_s3.zero    <= 1'b0;
		ctl_s3.inv     <= 1'b0;
		ctl_s3.is_acos <= (fr_o.act == ACT_ACOS);
		case (fr_o.act)
			ACT_ATAN: begin
				ay_s3       <= fr_o.xm;
				ax_s3       <= ONE_Q16;
				ctl_s3.yneg <= fr_o.xneg;
				ctl_s3.xneg <= 1'b0;
			end
			ACT_ATAN2: begin
				ay_s3       <= fr_o.ym;
				ax_s3       <= fr_o.xm;
				ctl_s3.yneg <= fr_o.yneg;
				ctl_s3.xneg <= fr_o.xneg;
			end
			default: begin
				ay_s3       <= {fr_o.xm[17:0], 14'b0};
				ax_s3       <= {1'b0, root};
				ctl_s3.yneg <= fr_o.xneg;
				ctl_s3.xneg <= 1'b0;
			end
		endcase
	end

	// Stage 4: order the magnitudes so that the ratio is at most one.
	logic        v_s4;
	logic [31:0] num_s4, den_s4;
	fpat_ctl_t   ctl_s4;
	logic        swap;

	assign swap = (ay_s3 > ax_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		num_s4 <= swap ? ax_s3 : ay_s3;
		den_s4 <= swap ? ay_s3 : ax_s3;
		ctl_s4 <= '{err: ctl_s3.err,
			zero: (ay_s3 == 32'd0) && (ax_s3 == 32'd0),
			inv: swap,
			xneg: ctl_s3.xneg,
			yneg: ctl_s3.yneg,
			is_acos: ctl_s3.is_acos};
	end

	// Ratio in Q.30.
	logic        rt_v;
	logic [30:0] ratio;
	fpat_ctl_t   rt_ctl;

	fpat_div #(
		.DEN_W  (32),
		.QB     (31),
		.SIDE_W ($bits(fpat_ctl_t))
	) u_ratio (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s4),
		.in_rem    ({1'b0, num_s4[31:1]}),
		.in_low    ({num_s4[0], 30'b0}),
		.in_den    (den_s4),
		.in_side   (ctl_s4),
		.out_valid (rt_v),
		.out_quo   (ratio),
		.out_side  (rt_ctl)
	);

	// Stage 5: square of the ratio.
	logic        v_s5;
	logic [30:0] r_s5, sq_s5;
	fpat_ctl_t   ctl_s5;
	logic [61:0] rsq;

	assign rsq = {31'b0, ratio} * {31'b0, ratio};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= rt_v;
		end
	end

	always_ff @(posedge clk) begin
		r_s5   <= ratio;
		sq_s5  <= rsq[60:30];
		ctl_s5 <= rt_ctl;
	end

	// Continued-fraction terms, innermost first.
	logic        tv    [MAX_TERMS+1];
	tside_t      ts    [MAX_TERMS+1];
	logic [33:0] tconv [MAX_TERMS+1];

	assign tv[0]    = v_s5;
	assign ts[0]    = '{r: r_s5, sq: sq_s5, ctl: ctl_s5};
	assign tconv[0] = '0;

	for (genvar k = 0; k < MAX_TERMS; k++) begin : g_term
		localparam int Z = MAX_TERMS - k;
		localparam logic [10:0] ZSQ  = 11'(Z * Z);
		localparam logic [6:0]  ZODD = 7'(2 * Z + 1);
		localparam logic [5:0]  ZNUM = 6'(Z);

		logic        v_st;
		logic [40:0] num_st;
		logic [36:0] den_st;
		tside_t      side_st;
		logic        dv;
		logic [33:0] quo;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_st <= 1'b0;
			end else begin
				v_st <= tv[k];
			end
		end

		// Term numerator z^2 * r^2 and denominator (2z+1) + previous term.
		always_ff @(posedge clk) begin
			num_st  <= {10'b0, ts[k].sq} * {30'b0, ZSQ};
			den_st  <= {ZODD, 30'b0} + {3'b0, tconv[k]};
			side_st <= ts[k];
		end

		fpat_div #(
			.DEN_W  (37),
			.QB     (34),
			.SIDE_W ($bits(tside_t))
		) u_term (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (v_st),
			.in_rem    (num_st[40:4]),
			.in_low    ({num_st[3:0], 30'b0}),
			.in_den    (den_st),
			.in_side   (side_st),
			.out_valid (dv),
			.out_quo   (quo),
			.out_side  (ts[k+1])
		);

		// Terms beyond the configured count contribute nothing.
		assign tv[k+1]    = dv;
		assign tconv[k+1] = (ZNUM <= {1'b0, term_count_q}) ? quo : 34'd0;
	end

	// Stage 6: final division r / (1 + conv).
	logic        v_s6;
	logic [34:0] fden_s6;
	logic [30:0] r_s6;
	fpat_ctl_t   ctl_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else begin
			v_s6 <= tv[MAX_TERMS];
		end
	end

	always_ff @(posedge clk) begin
		fden_s6 <= 35'h4000_0000 + {1'b0, tconv[MAX_TERMS]};
		r_s6    <= ts[MAX_TERMS].r;
		ctl_s6  <= ts[MAX_TERMS].ctl;
	end

	logic        fv;
	logic [30:0] atn;
	fpat_ctl_t   f_ctl;

	fpat_div #(
		.DEN_W  (35),
		.QB     (31),
		.SIDE_W ($bits(fpat_ctl_t))
	) u_final (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s6),
		.in_rem    ({5'b0, r_s6[30:1]}),
		.in_low    ({r_s6[0], 30'b0}),
		.in_den    (fden_s6),
		.in_side   (ctl_s6),
		.out_valid (fv),
		.out_quo   (atn),
		.out_side  (f_ctl)
	);

	// Stage 7: undo the inversion.
	logic        v_s7;
	logic [31:0] m_s7;
	fpat_ctl_t   ctl_s7;

	// Stage 8: quadrant correction for negative x.
	logic        v_s8;
	logic [31:0] m_s8;
	fpat_ctl_t   ctl_s8;

	// Stage 9: sign and the acos offset.
	logic        v_s9;
	logic [32:0] mag_s9;
	logic        neg_s9;
	logic        err_s9;

	// Stage 10: round half up to Q.28.
	logic        v_s10;
	logic [30:0] q_s10;
	logic        neg_s10;
	logic        err_s10;
	logic [32:0] rnd;

	assign rnd = mag_s9 + 33'd2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			done  <= 1'b0;
		end else begin
			v_s7  <= fv;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			done  <= v_s10;
		end
	end

	always_ff @(posedge clk) begin
		m_s7   <= f_ctl.inv ? (HALF_PI_Q30 - {1'b0, atn}) : {1'b0, atn};
		ctl_s7 <= f_ctl;

		if (ctl_s7.zero) begin
			m_s8 <= 32'd0;
		end else begin
			m_s8 <= ctl_s7.xneg ? (PI_Q30 - m_s7) : m_s7;
		end
		ctl_s8 <= ctl_s7;

		if (ctl_s8.is_acos) begin
			mag_s9 <= ctl_s8.yneg ? ({1'b0, HALF_PI_Q30} + {1'b0, m_s8})
				: ({1'b0, HALF_PI_Q30} - {1'b0, m_s8});
		end else begin
			mag_s9 <= {1'b0, m_s8};
		end
		neg_s9 <= !ctl_s8.is_acos && ctl_s8.yneg;
		err_s9 <= ctl_s8.err;

		q_s10   <= rnd[32:2];
		neg_s10 <= neg_s9;
		err_s10 <= err_s9;

		// Result register.
		if (err_s10) begin
			result.angle <= 32'sd0;
		end else begin
			result.angle <= neg_s10 ? (~{1'b0, q_s10} + 32'd1) : {1'b0, q_s10};
		end
		result.status <= err_s10;
	end

endmodule

`default_nettype wire

[src/fpat_div.sv]
// ============================================================================
// fpat_div
// Pipelined restoring divider, one quotient bit per register stage.
// ============================================================================
`default_nettype none

module fpat_div #(
	parameter int DEN_W  = 32,
	parameter int QB     = 31,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [DEN_W-1:0]  in_rem,
	input  logic [QB-1:0]     in_low,
	input  logic [DEN_W-1:0]  in_den,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [QB-1:0]     out_quo,
	output logic [SIDE_W-1:0] out_side
);

	logic [QB-1:0]     vld_s;
	logic [DEN_W-1:0]  rem_s  [QB];
	logic [QB-1:0]     lq_s   [QB];
	logic [DEN_W-1:0]  den_s  [QB];
	logic [SIDE_W-1:0] side_s [QB];

	// Valid bits travel alongside the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[QB-2:0], in_valid};
		end
	end

	// Each stage brings in one dividend bit and decides one quotient bit.
	for (genvar k = 0; k < QB; k++) begin : g_step
		logic [DEN_W-1:0]  src_rem;
		logic [QB-1:0]     src_lq;
		logic [DEN_W-1:0]  src_den;
		logic [SIDE_W-1:0] src_side;
		logic [DEN_W:0]    shf;
		logic [DEN_W:0]    dif;
		logic              take;

		if (k == 0) begin : g_first
			assign src_rem  = in_rem;
			assign src_lq   = in_low;
			assign src_den  = in_den;
			assign src_side = in_side;
		end else begin : g_next
			assign src_rem  = rem_s[k-1];
			assign src_lq   = lq_s[k-1];
			assign src_den  = den_s[k-1];
			assign src_side = side_s[k-1];
		end

		always_comb begin
			shf  = {src_rem, src_lq[QB-1]};
			dif  = shf - {1'b0, src_den};
			take = (shf >= {1'b0, src_den});
		end

		always_ff @(posedge clk) begin
			rem_s[k]  <= take ? dif[DEN_W-1:0] : shf[DEN_W-1:0];
			lq_s[k]   <= {src_lq[QB-2:0], take};
			den_s[k]  <= src_den;
			side_s[k] <= src_side;
		end
	end

	assign out_valid = vld_s[QB-1];
	assign out_quo   = lq_s[QB-1];
	assign out_side  = side_s[QB-1];

endmodule

`default_nettype wire

[src/fpat_sqrt.sv]
// ============================================================================
// fpat_sqrt
// Pipelined integer square root, one root bit per register stage.
// ============================================================================
`default_nettype none

module fpat_sqrt #(
	parameter int RW     = 31,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [2*RW-1:0]   in_rad,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [RW-1:0]     out_root,
	output logic [SIDE_W-1:0] out_side
);

	logic [RW-1:0]     vld_s;
	logic [RW+1:0]     rem_s  [RW];
	logic [RW-1:0]     root_s [RW];
	logic [2*RW-1:0]   rad_s  [RW];
	logic [SIDE_W-1:0] side_s [RW];

	// Valid bits travel alongside the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[RW-2:0], in_valid};
		end
	end

	// Each stage takes two radicand bits and settles one root bit.
	for (genvar k = 0; k < RW; k++) begin : g_step
		logic [RW+1:0]     src_rem;
		logic [RW-1:0]     src_root;
		logic [2*RW-1:0]   src_rad;
		logic [SIDE_W-1:0] src_side;
		logic [RW+3:0]     shf;
		logic [RW+3:0]     trial;
		logic [RW+3:0]     dif;
		logic              take;

		if (k == 0) begin : g_first
			assign src_rem  = '0;
			assign src_root = '0;
			assign src_rad  = in_rad;
			assign src_side = in_side;
		end else begin : g_next
			assign src_rem  = rem_s[k-1];
			assign src_root = root_s[k-1];
			assign src_rad  = rad_s[k-1];
			assign src_side = side_s[k-1];
		end

		always_comb begin
			shf   = {src_rem, src_rad[2*RW-1 -: 2]};
			trial = {2'b00, src_root, 2'b01};
			dif   = shf - trial;
			take  = (shf >= trial);
		end

		always_ff @(posedge clk) begin
			rem_s[k]  <= take ? dif[RW+1:0] : shf[RW+1:0];
			root_s[k] <= {src_root[RW-2:0], take};
			rad_s[k]  <= {src_rad[2*RW-3:0], 2'b00};
			side_s[k] <= src_side;
		end
	end

	assign out_valid = vld_s[RW-1];
	assign out_root  = root_s[RW-1];
	assign out_side  = side_s[RW-1];

endmodule

`default_nettype wire

[src/fpat_checker.sv]
// ============================================================================
// fpat_port_checker
// Port-level checks on the arctangent unit, bound to the top level.
// ============================================================================
`default_nettype none

`include "fixed_point_arctangent_unit_defines.svh"

module fpat_port_checker #(
	parameter int MAX_TERMS = fpat_pkg::MAX_TERMS_DEF
) (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic                done,
	input fpat_pkg::fpat_out_t result
);
	import fpat_pkg::*;

	localparam int LAT = 104 + 35 * MAX_TERMS;

	// The unit takes a transaction in every cycle.
	`FPAT_ASSERT(a_never_busy, !busy, "busy raised on a fully pipelined unit")

	// A domain error carries a zero angle.
	`FPAT_ASSERT(a_err_angle, (done && result.status) |-> (result.angle == 32'sd0), "domain error with nonzero angle")

	// A valid angle lies within plus or minus pi in Q4.28.
	`FPAT_ASSERT(a_range, (done && !result.status) |-> ((result.angle <= 32'sd843314857) && (result.angle >= -32'sd843314857)), "angle outside plus or minus pi")

	// Every result belongs to a transaction taken the pipeline depth earlier.
	`FPAT_ASSERT(a_no_orphan, done |-> $past(start && !busy, LAT), "result without a matching transaction")

endmodule

bind fixed_point_arctangent_unit fpat_port_checker #(
	.MAX_TERMS (MAX_TERMS)
) u_fpat_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

`default_nettype wire
